[src/dmat_pkg.sv]
// Shared types and constants of the drift-mode attitude and throttle step unit.
`default_nettype none
package dmat_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_YAW_RATE_GAIN      = 3'd0,
		REG_SPEED_GAIN         = 3'd1,
		REG_SPEED_LIMIT        = 3'd2,
		REG_ASSIST_GAIN        = 3'd3,
		REG_ASSIST_MAX         = 3'd4,
		REG_ASSIST_WINDOW_LOW  = 3'd5,
		REG_ASSIST_WINDOW_HIGH = 3'd6
	} cfg_reg_t;

	// Datapath sequence, one step per cycle
	typedef enum logic [4:0] {
		ST_ROT0        = 5'd0,
		ST_ROT1        = 5'd1,
		ST_ROT2        = 5'd2,
		ST_ROT3        = 5'd3,
		ST_YAW0        = 5'd4,
		ST_YAW1        = 5'd5,
		ST_YAW_DIV     = 5'd6,
		ST_YAW_REC     = 5'd7,
		ST_YAW_CHK     = 5'd8,
		ST_YAW_FIN     = 5'd9,
		ST_SF_DIV      = 5'd10,
		ST_SF_REC      = 5'd11,
		ST_SF_CHK      = 5'd12,
		ST_SF_FIN      = 5'd13,
		ST_ROLL0       = 5'd14,
		ST_ROLL1       = 5'd15,
		ST_ROLL_DIV    = 5'd16,
		ST_ROLL_REC    = 5'd17,
		ST_ROLL_CHK    = 5'd18,
		ST_ROLL_FIN    = 5'd19,
		ST_BRAKE       = 5'd20,
		ST_PITCH_DIV   = 5'd21,
		ST_PITCH_REC   = 5'd22,
		ST_PITCH_CHK   = 5'd23,
		ST_PITCH_FIN   = 5'd24,
		ST_AST0        = 5'd25,
		ST_AST1        = 5'd26,
		ST_AST_DIV     = 5'd27,
		ST_AST_REC     = 5'd28,
		ST_AST_CHK     = 5'd29,
		ST_AST_FIN     = 5'd30
	} step_t;

	localparam step_t LAST_STEP = ST_AST_FIN;

	typedef struct packed {
		logic  load;    // capture input item
		logic  run;     // step is live
		step_t step;
		logic  commit;  // copy results to output register
	} dmat_cmd_t;

endpackage
`default_nettype wire

[src/dmat_if.sv]
// Channel interfaces: input tick, result and configuration write.
`default_nettype none
interface dmat_tick_if;
	logic                valid;
	logic                ready;
	logic signed [14:0]  pilot_roll;
	logic signed [14:0]  pilot_pitch;
	logic signed [13:0]  vel_north;
	logic signed [13:0]  vel_east;
	logic signed [13:0]  vertical_speed;
	logic signed [15:0]  yaw_sin;
	logic signed [15:0]  yaw_cos;
	logic signed [13:0]  yaw_stick;
	logic        [12:0]  pilot_throttle;

	modport source (
		output valid, pilot_roll, pilot_pitch, vel_north, vel_east, vertical_speed,
		output yaw_sin, yaw_cos, yaw_stick, pilot_throttle,
		input  ready
	);
	modport sink (
		input  valid, pilot_roll, pilot_pitch, vel_north, vel_east, vertical_speed,
		input  yaw_sin, yaw_cos, yaw_stick, pilot_throttle,
		output ready
	);
endinterface

interface dmat_result_if;
	logic                valid;
	logic                ready;
	logic signed [13:0]  roll_cmd;
	logic signed [15:0]  pitch_cmd;
	logic signed [17:0]  yaw_rate_cmd;
	logic        [12:0]  throttle_out;

	modport source (
		output valid, roll_cmd, pitch_cmd, yaw_rate_cmd, throttle_out,
		input  ready
	);
	modport sink (
		input  valid, roll_cmd, pitch_cmd, yaw_rate_cmd, throttle_out,
		output ready
	);
endinterface

interface dmat_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/dmat_ctrl.sv]
// Sequencer: accepts a tick, steps the datapath, hands off to the output register.
`default_nettype none
module dmat_ctrl import dmat_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic      out_ready,
	output logic           out_valid,
	output dmat_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   out_valid_q;
	logic   accept;
	logic   free;

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign free       = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;

	assign cmd.load   = accept;
	assign cmd.run    = (state_q == S_RUN);
	assign cmd.step   = step_q;
	assign cmd.commit = (state_q == S_HOLD) && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_ROT0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						step_q  <= ST_ROT0;
					end
				end
				S_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_HOLD;
					end else begin
						step_q <= step_t'(5'(step_q) + 5'd1);
					end
				end
				S_HOLD: begin
					if (free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[src/dmat_datapath.sv]
// Datapath: config registers, shared multiplier, constant divider and state.
`default_nettype none
module dmat_datapath import dmat_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dmat_cmd_t               cmd,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic signed [14:0]      pilot_roll,
	input  wire logic signed [14:0]      pilot_pitch,
	input  wire logic signed [13:0]      vel_north,
	input  wire logic signed [13:0]      vel_east,
	input  wire logic signed [13:0]      vertical_speed,
	input  wire logic signed [15:0]      yaw_sin,
	input  wire logic signed [15:0]      yaw_cos,
	input  wire logic signed [13:0]      yaw_stick,
	input  wire logic        [12:0]      pilot_throttle,
	output logic signed [13:0]           roll_cmd,
	output logic signed [15:0]           pitch_cmd,
	output logic signed [17:0]           yaw_rate_cmd,
	output logic        [12:0]           throttle_out
);

	typedef enum logic [2:0] {
		DK_YAW, DK_SF, DK_ROLL, DK_PITCH, DK_AST
	} div_kind_t;

	localparam logic        [26:0] YAW_FULL  = 27'd81920000;  // 5000 * 2^14
	localparam logic        [30:0] YAW_CAP   = 31'd32768000;  // 2000 * 2^14
	localparam logic signed [32:0] YAW_LIM   = 33'sd72000;
	localparam logic signed [32:0] ROLL_LIM  = 33'sd4500;
	localparam logic signed [32:0] PITCH_LIM = 33'sd32000;

	// config
	logic [11:0] yaw_gain_q;
	logic [10:0] speed_gain_q;
	logic [10:0] speed_limit_q;
	logic [15:0] assist_gain_q;
	logic [12:0] assist_max_q;
	logic [12:0] win_lo_q;
	logic [12:0] win_hi_q;

	// captured item
	logic signed [14:0] roll_in_q, pitch_in_q;
	logic signed [13:0] vn_q, ve_q, vz_q, stick_q;
	logic signed [15:0] sn_q, cs_q;
	logic        [12:0] thr_q;

	// working registers
	logic signed [65:0] p_q;
	logic signed [30:0] rv_q, pv_q;
	logic signed [25:0] rvc_q, pvc_q;
	logic signed [36:0] acc_q;
	logic        [31:0] t_q, q0_q;
	logic               neg_q;
	div_kind_t          kind_q;

	// state and results
	logic signed [21:0] sf_q;
	logic        [10:0] bf_q;
	logic signed [17:0] yaw_q;
	logic signed [13:0] roll_q;
	logic signed [15:0] pitch_q;
	logic        [12:0] tout_q;

	logic signed [32:0] ma, mb;

	// combinational helpers
	logic        [30:0] apv, apv_c;
	logic        [26:0] yaw_fac;
	logic signed [26:0] lim;
	logic        [11:0] bf_sum;
	logic        [10:0] bf_next;
	logic        [12:0] d_mid;
	logic signed [20:0] w_raw;
	logic        [16:0] w_cl;
	logic signed [55:0] num, mag;
	div_kind_t          kind_d;
	logic        [31:0] t_d;
	logic        [27:0] m_rec;
	logic        [12:0] k_div;
	logic        [32:0] r_div;
	logic        [31:0] q_div;
	logic signed [32:0] sq;
	logic signed [32:0] amax, a_cl;
	logic signed [14:0] tsum;
	logic        [12:0] tout_d;
	logic               in_window;

	always_comb begin
		apv     = pv_q[30] ? 31'(-pv_q) : 31'(pv_q);
		apv_c   = (apv > YAW_CAP) ? YAW_CAP : apv;
		yaw_fac = YAW_FULL - 27'(apv_c);
		lim     = 27'({speed_limit_q, 14'd0});
		bf_sum  = 12'(bf_q) + 12'd3;
		bf_next = (bf_sum > 12'(speed_gain_q)) ? speed_gain_q : bf_sum[10:0];
		d_mid   = (thr_q >= 13'd2048) ? (thr_q - 13'd2048) : (13'd2048 - thr_q);
		w_raw   = 21'sd147456 - 21'(d_mid) * 21'sd125;
		if (w_raw < 0) begin
			w_cl = 17'd0;
		end else if (w_raw > 21'sd122880) begin
			w_cl = 17'd122880;
		end else begin
			w_cl = w_raw[16:0];
		end
		in_window = (thr_q > win_lo_q) && (thr_q < win_hi_q);
	end

	// numerator selection for the divider setup steps
	always_comb begin
		num    = '0;
		kind_d = DK_YAW;
		case (cmd.step)
			ST_YAW_DIV: begin
				num    = 56'(p_q);
				kind_d = DK_YAW;
			end
			ST_SF_DIV: begin
				num    = (56'(sf_q) <<< 4) + (56'(sf_q) <<< 3) + (56'(stick_q) <<< 8);
				kind_d = DK_SF;
			end
			ST_ROLL_DIV: begin
				num    = 56'(acc_q) - 56'(signed'(p_q[37:0]));
				kind_d = DK_ROLL;
			end
			ST_PITCH_DIV: begin
				num    = 56'(signed'(p_q[37:0]));
				kind_d = DK_PITCH;
			end
			ST_AST_DIV: begin
				num    = -56'(signed'(p_q[48:0]));
				kind_d = DK_AST;
			end
			default: begin
				num    = '0;
				kind_d = DK_YAW;
			end
		endcase
		mag = num[55] ? -num : num;
		// round half away: add half the divisor, drop the power-of-two part
		case (kind_d)
			DK_YAW:   t_d = 32'((mag + 56'd10485760000) >> 22);
			DK_SF:    t_d = 32'(mag + 56'd12);
			DK_ROLL:  t_d = 32'((mag + 56'd819200) >> 14);
			DK_PITCH: t_d = 32'((mag + 56'd819200) >> 14);
			DK_AST:   t_d = 32'((mag + 56'd15728640) >> 20);
			default:  t_d = '0;
		endcase
	end

	// reciprocal floor(2^32/k); quotient estimate is exact or one short
	always_comb begin
		case (kind_q)
			DK_YAW:   begin m_rec = 28'd858993;    k_div = 13'd5000; end
			DK_SF:    begin m_rec = 28'd171798691; k_div = 13'd25;   end
			DK_ROLL:  begin m_rec = 28'd42949672;  k_div = 13'd100;  end
			DK_PITCH: begin m_rec = 28'd42949672;  k_div = 13'd100;  end
			DK_AST:   begin m_rec = 28'd143165576; k_div = 13'd30;   end
			default:  begin m_rec = '0;            k_div = 13'd1;    end
		endcase
		r_div = 33'(t_q) - 33'(p_q[32:0]);
		q_div = (r_div >= 33'(k_div)) ? (q0_q + 32'd1) : q0_q;
		sq    = neg_q ? -33'(q_div) : 33'(q_div);
		amax  = 33'(assist_max_q);
		if (!in_window) begin
			a_cl = '0;
		end else if (sq > amax) begin
			a_cl = amax;
		end else if (sq < -amax) begin
			a_cl = -amax;
		end else begin
			a_cl = sq;
		end
		tsum = 15'(signed'({2'b00, thr_q})) + 15'(a_cl);
		if (tsum < 0) begin
			tout_d = 13'd0;
		end else if (tsum > 15'sd4096) begin
			tout_d = 13'd4096;
		end else begin
			tout_d = tsum[12:0];
		end
	end

	// multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		if (cmd.run) begin
			case (cmd.step)
				ST_ROT0: begin ma = 33'(ve_q); mb = 33'(cs_q); end
				ST_ROT1: begin ma = 33'(vn_q); mb = 33'(sn_q); end
				ST_ROT2: begin ma = 33'(ve_q); mb = 33'(sn_q); end
				ST_ROT3: begin ma = 33'(vn_q); mb = 33'(cs_q); end
				ST_YAW0: begin ma = 33'(roll_in_q); mb = 33'(yaw_gain_q); end
				ST_YAW1: begin ma = 33'(signed'(p_q[26:0])); mb = 33'(yaw_fac); end
				ST_YAW_REC, ST_SF_REC, ST_ROLL_REC, ST_PITCH_REC, ST_AST_REC: begin
					ma = 33'(t_q);
					mb = 33'(m_rec);
				end
				ST_YAW_CHK, ST_SF_CHK, ST_ROLL_CHK, ST_PITCH_CHK, ST_AST_CHK: begin
					ma = 33'(p_q[63:32]);
					mb = 33'(k_div);
				end
				ST_ROLL0: begin ma = 33'(sf_q); mb = 33'sd6400; end
				ST_ROLL1: begin ma = 33'(rvc_q); mb = 33'(speed_gain_q); end
				ST_BRAKE: begin ma = 33'(pvc_q); mb = 33'(bf_next); end
				ST_AST0:  begin ma = 33'(w_cl); mb = 33'(vz_q); end
				ST_AST1:  begin ma = 33'(signed'(p_q[30:0])); mb = 33'(assist_gain_q); end
				default:  begin ma = '0; mb = '0; end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_gain_q    <= 12'd1152;
			speed_gain_q  <= 11'd800;
			speed_limit_q <= 11'd560;
			assist_gain_q <= 16'd1887;
			assist_max_q  <= 13'd1229;
			win_lo_q      <= 13'd872;
			win_hi_q      <= 13'd3224;
			sf_q          <= '0;
			bf_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_YAW_RATE_GAIN:      yaw_gain_q    <= cfg_data[11:0];
					REG_SPEED_GAIN:         speed_gain_q  <= cfg_data[10:0];
					REG_SPEED_LIMIT:        speed_limit_q <= cfg_data[10:0];
					REG_ASSIST_GAIN:        assist_gain_q <= cfg_data;
					REG_ASSIST_MAX:         assist_max_q  <= cfg_data[12:0];
					REG_ASSIST_WINDOW_LOW:  win_lo_q      <= cfg_data[12:0];
					REG_ASSIST_WINDOW_HIGH: win_hi_q      <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (cmd.run && cmd.step == ST_SF_FIN) begin
				sf_q <= sq[21:0];
			end
			if (cmd.run && cmd.step == ST_BRAKE) begin
				bf_q <= (pitch_in_q == '0) ? bf_next : 11'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (cmd.load) begin
			roll_in_q  <= pilot_roll;
			pitch_in_q <= pilot_pitch;
			vn_q       <= vel_north;
			ve_q       <= vel_east;
			vz_q       <= vertical_speed;
			sn_q       <= yaw_sin;
			cs_q       <= yaw_cos;
			stick_q    <= yaw_stick;
			thr_q      <= pilot_throttle;
		end
		if (cmd.run) begin
			case (cmd.step)
				ST_ROT1: rv_q <= 31'(p_q);
				ST_ROT2: rv_q <= rv_q - 31'(p_q);
				ST_ROT3: pv_q <= 31'(p_q);
				ST_YAW0: pv_q <= pv_q + 31'(p_q);
				ST_YAW1: begin
					// speed clamp after the yaw factor has used raw pv
					if (rv_q > 31'(lim)) begin
						rvc_q <= 26'(lim);
					end else if (rv_q < -31'(lim)) begin
						rvc_q <= 26'(-lim);
					end else begin
						rvc_q <= 26'(rv_q);
					end
					if (pv_q > 31'(lim)) begin
						pvc_q <= 26'(lim);
					end else if (pv_q < -31'(lim)) begin
						pvc_q <= 26'(-lim);
					end else begin
						pvc_q <= 26'(pv_q);
					end
				end
				ST_YAW_DIV, ST_SF_DIV, ST_ROLL_DIV, ST_PITCH_DIV, ST_AST_DIV: begin
					t_q    <= t_d;
					neg_q  <= num[55];
					kind_q <= kind_d;
				end
				ST_YAW_CHK, ST_SF_CHK, ST_ROLL_CHK, ST_PITCH_CHK, ST_AST_CHK: begin
					q0_q <= p_q[63:32];
				end
				ST_YAW_FIN: begin
					if (sq > YAW_LIM) begin
						yaw_q <= 18'(YAW_LIM);
					end else if (sq < -YAW_LIM) begin
						yaw_q <= 18'(-YAW_LIM);
					end else begin
						yaw_q <= 18'(sq);
					end
				end
				ST_ROLL1: acc_q <= 37'(p_q);
				ST_ROLL_FIN: begin
					if (sq > ROLL_LIM) begin
						roll_q <= 14'(ROLL_LIM);
					end else if (sq < -ROLL_LIM) begin
						roll_q <= 14'(-ROLL_LIM);
					end else begin
						roll_q <= 14'(sq);
					end
				end
				ST_PITCH_FIN: begin
					if (pitch_in_q != '0) begin
						pitch_q <= 16'(pitch_in_q);
					end else if (sq > PITCH_LIM) begin
						pitch_q <= 16'(PITCH_LIM);
					end else if (sq < -PITCH_LIM) begin
						pitch_q <= 16'(-PITCH_LIM);
					end else begin
						pitch_q <= 16'(sq);
					end
				end
				ST_AST_FIN: tout_q <= tout_d;
				default: ;
			endcase
		end
		if (cmd.commit) begin
			roll_cmd     <= roll_q;
			pitch_cmd    <= pitch_q;
			yaw_rate_cmd <= yaw_q;
			throttle_out <= tout_q;
		end
	end

endmodule
`default_nettype wire

[src/drift_mode_attitude_throttle_step_unit.sv]
// Drift-mode attitude and throttle step unit, top level.
//
// One tick item in, one result item out, valid/ready on both channels.
// A tick transfers when tick.valid and tick.ready are high at a clock edge;
// the unit then runs a 31-step sequence on one shared 33x33 multiplier and
// a reciprocal-multiply divider, then puts the result on the result channel.
// The unit takes no new tick while one is in the sequence; the
// next tick is taken the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the unit
// finishes the current tick and waits until the register frees up.
// Configuration writes go on the cfg channel (always ready), while idle;
// indexes beyond the register list are dropped.
// Reset (arst_n low) restores register defaults, clears the stick filter
// and brake factor, and empties the output register.
`default_nettype none
module drift_mode_attitude_throttle_step_unit import dmat_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dmat_tick_if.sink      tick,
	dmat_result_if.source  result,
	dmat_cfg_if.sink       cfg
);

	dmat_cmd_t cmd;

	assign cfg.ready = 1'b1;

	dmat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.cmd       (cmd)
	);

	dmat_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.pilot_roll      (tick.pilot_roll),
		.pilot_pitch     (tick.pilot_pitch),
		.vel_north       (tick.vel_north),
		.vel_east        (tick.vel_east),
		.vertical_speed  (tick.vertical_speed),
		.yaw_sin         (tick.yaw_sin),
		.yaw_cos         (tick.yaw_cos),
		.yaw_stick       (tick.yaw_stick),
		.pilot_throttle  (tick.pilot_throttle),
		.roll_cmd        (result.roll_cmd),
		.pitch_cmd       (result.pitch_cmd),
		.yaw_rate_cmd    (result.yaw_rate_cmd),
		.throttle_out    (result.throttle_out)
	);

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tick.ready |-> (!cmd.run && !cmd.commit))
		else $error("tick ready while sequence active");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!result.valid || result.ready))
		else $error("result overwritten before transfer");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> (!tick.ready && cmd.run && cmd.step == ST_ROT0))
		else $error("sequence did not start after tick transfer");
`endif

endmodule
`default_nettype wire

[verif/tb_drift_mode_attitude_throttle_step_unit.sv]
// Testbench for the drift-mode attitude and throttle step unit: an own model predicts every result.
`default_nettype none
module tb_drift_mode_attitude_throttle_step_unit import dmat_pkg::*;;

	typedef struct packed {
		logic signed [14:0] pilot_roll;
		logic signed [14:0] pilot_pitch;
		logic signed [13:0] vel_north;
		logic signed [13:0] vel_east;
		logic signed [13:0] vertical_speed;
		logic signed [15:0] yaw_sin;
		logic signed [15:0] yaw_cos;
		logic signed [13:0] yaw_stick;
		logic        [12:0] pilot_throttle;
	} tick_t;

	typedef struct packed {
		logic signed [13:0] roll_cmd;
		logic signed [15:0] pitch_cmd;
		logic signed [17:0] yaw_rate_cmd;
		logic        [12:0] throttle_out;
	} targets_t;

	localparam longint Q14 = 16384;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dmat_tick_if   tick();
	dmat_result_if result();
	dmat_cfg_if    cfg();

	drift_mode_attitude_throttle_step_unit uut (
		.clk(clk), .arst_n(arst_n), .tick(tick.sink), .result(result.source), .cfg(cfg.sink)
	);

	// predictor copy of registers and state
	longint yaw_rate_gain, speed_gain, speed_limit, assist_gain;
	longint assist_max, window_low, window_high;
	longint stick_lp, brake;

	targets_t expected_targets[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic longint rdiv(longint num, longint den);
		longint mag;
		mag = num < 0 ? -num : num;
		mag = (mag + den / 2) / den;
		return num < 0 ? -mag : mag;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, longint value);
		case (idx)
			REG_YAW_RATE_GAIN: yaw_rate_gain = value & 'hFFF;
			REG_SPEED_GAIN: speed_gain = value & 'h7FF;
			REG_SPEED_LIMIT: speed_limit = value & 'h7FF;
			REG_ASSIST_GAIN: assist_gain = value & 'hFFFF;
			REG_ASSIST_MAX: assist_max = value & 'h1FFF;
			REG_ASSIST_WINDOW_LOW: window_low = value & 'h1FFF;
			REG_ASSIST_WINDOW_HIGH: window_high = value & 'h1FFF;
			default: ;
		endcase
	endfunction

	function automatic targets_t drift_step(tick_t t);
		longint roll_spd, pitch_spd, apv, yaw, lim, troll, tpitch, assist, thr, d, w;
		targets_t r;
		roll_spd = longint'(t.vel_east) * t.yaw_cos - longint'(t.vel_north) * t.yaw_sin;
		pitch_spd = longint'(t.vel_east) * t.yaw_sin + longint'(t.vel_north) * t.yaw_cos;
		apv = pitch_spd < 0 ? -pitch_spd : pitch_spd;
		apv = clip(apv, 0, 2000 * Q14);
		yaw = rdiv(longint'(t.pilot_roll) * (5000 * Q14 - apv) * yaw_rate_gain,
			5000 * Q14 * 256);
		yaw = clip(yaw, -72000, 72000);
		lim = speed_limit * Q14;
		roll_spd = clip(roll_spd, -lim, lim);
		pitch_spd = clip(pitch_spd, -lim, lim);
		stick_lp = rdiv(24 * stick_lp + 256 * longint'(t.yaw_stick), 25);
		troll = clip(rdiv(stick_lp * 6400 - roll_spd * speed_gain, 100 * Q14), -4500, 4500);
		if (t.pilot_pitch == 0) begin
			brake = brake + 3;
			if (brake > speed_gain) brake = speed_gain;
			tpitch = clip(rdiv(pitch_spd * brake, 100 * Q14), -32000, 32000);
		end else begin
			brake = 0;
			tpitch = longint'(t.pilot_pitch);
		end
		thr = longint'(t.pilot_throttle);
		assist = 0;
		if (thr > window_low && thr < window_high) begin
			d = thr - 2048;
			if (d < 0) d = -d;
			w = clip(147456 - 125 * d, 0, 122880);
			assist = rdiv(-(w * assist_gain * longint'(t.vertical_speed)), longint'(30) << 20);
			assist = clip(assist, -assist_max, assist_max);
		end
		r.roll_cmd = 14'(troll);
		r.pitch_cmd = 16'(tpitch);
		r.yaw_rate_cmd = 18'(yaw);
		r.throttle_out = 13'(clip(thr + assist, 0, 4096));
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// result side: random stall plus optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result.ready <= 1'b0;
		end else
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		targets_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_targets.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_targets.pop_front();
				if (result.roll_cmd !== want.roll_cmd)
					report_mismatch("roll_cmd", longint'(result.roll_cmd),
						longint'(want.roll_cmd));
				if (result.pitch_cmd !== want.pitch_cmd)
					report_mismatch("pitch_cmd", longint'(result.pitch_cmd),
						longint'(want.pitch_cmd));
				if (result.yaw_rate_cmd !== want.yaw_rate_cmd)
					report_mismatch("yaw_rate_cmd", longint'(result.yaw_rate_cmd),
						longint'(want.yaw_rate_cmd));
				if (result.throttle_out !== want.throttle_out)
					report_mismatch("throttle_out", longint'(result.throttle_out),
						longint'(want.throttle_out));
			end
		end
	end

	task automatic send_tick(tick_t t);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		tick.valid <= 1'b1;
		{tick.pilot_roll, tick.pilot_pitch, tick.vel_north, tick.vel_east, tick.vertical_speed,
			tick.yaw_sin, tick.yaw_cos, tick.yaw_stick, tick.pilot_throttle} <= t;
		do @(posedge clk); while (!tick.ready);
		expected_targets.push_back(drift_step(t));
		tick.valid <= 1'b0;
		// block is busy for the whole sequence after a transfer
		@(posedge clk);
	endtask

	task automatic drain;
		while (expected_targets.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		apply_reg(idx, longint'(value));
	endtask

	function automatic tick_t random_tick();
		tick_t t;
		t.pilot_roll = 15'($urandom_range(18000) - 9000);
		t.pilot_pitch = ($urandom_range(2) == 0) ? 15'sd0 : 15'($urandom_range(18000) - 9000);
		t.vel_north = 14'($urandom);
		t.vel_east = 14'($urandom);
		t.vertical_speed = ($urandom_range(1) == 0) ? 14'($urandom_range(800) - 400) :
			14'($urandom);
		t.yaw_sin = 16'($urandom_range(32768) - 16384);
		t.yaw_cos = 16'($urandom_range(32768) - 16384);
		t.yaw_stick = ($urandom_range(9) == 0) ? 14'($urandom) :
			14'($urandom_range(9000) - 4500);
		t.pilot_throttle = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(4096));
		return t;
	endfunction

	task automatic test_directed;
		tick_t t;
		for (int i = 0; i < 20; i++) begin
			t = random_tick();
			case (i % 5)
				0: t = '{9000, 0, 8191, -8192, 8191, 16384, -16384, 4500, 4096};
				1: t = '{-9000, -9000, -8192, 8191, -8192, -16384, 16384, -4500, 0};
				2: t = '{15'h7FFF, 15'h4000, 14'h1FFF, 14'h2000, 14'h2000, 16'h8000, 16'h7FFF,
					14'h2000, 13'h1FFF};
				3: t.pilot_throttle = 13'd2048;
				default: t.pilot_pitch = 15'sd0;
			endcase
			send_tick(t);
		end
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_tick(random_tick());
	endtask

	task automatic test_backpressure;
		hold_cycles <= 600;
		@(posedge clk);
		test_random(20);
		drain();
		test_random(10);
	endtask

	task automatic test_config(int setting);
		drain();
		case (setting)
			0: begin
				write_reg(REG_YAW_RATE_GAIN, 16'd4095); write_reg(REG_SPEED_GAIN, 16'd1600);
				write_reg(REG_SPEED_LIMIT, 16'd2000); write_reg(REG_ASSIST_GAIN, 16'd65535);
				write_reg(REG_ASSIST_MAX, 16'd4096); write_reg(REG_ASSIST_WINDOW_LOW, 16'd0);
				write_reg(REG_ASSIST_WINDOW_HIGH, 16'd4096);
			end
			1: begin
				write_reg(REG_YAW_RATE_GAIN, 16'd0); write_reg(REG_SPEED_GAIN, 16'd1);
				write_reg(REG_SPEED_LIMIT, 16'd0); write_reg(REG_ASSIST_GAIN, 16'd0);
				write_reg(REG_ASSIST_MAX, 16'd0); write_reg(REG_ASSIST_WINDOW_LOW, 16'd4096);
				write_reg(REG_ASSIST_WINDOW_HIGH, 16'd0);
			end
			2: begin
				// zero speed gain, oversized fields, and an unlisted index
				write_reg(REG_SPEED_GAIN, 16'd0); write_reg(REG_ASSIST_MAX, 16'hFFFF);
				write_reg(REG_ASSIST_WINDOW_HIGH, 16'hFFFF); write_reg(REG_SPEED_LIMIT, 16'hFFFF);
				write_reg(REG_ASSIST_GAIN, 16'($urandom)); write_reg(cfg_reg_t'(3'd7), 16'h1234);
			end
			default: begin
				write_reg(REG_YAW_RATE_GAIN, 16'($urandom_range(4095)));
				write_reg(REG_SPEED_GAIN, 16'($urandom_range(1600, 1)));
				write_reg(REG_SPEED_LIMIT, 16'($urandom_range(2000)));
				write_reg(REG_ASSIST_GAIN, 16'($urandom_range(4000)));
				write_reg(REG_ASSIST_MAX, 16'($urandom_range(4096)));
				write_reg(REG_ASSIST_WINDOW_LOW, 16'($urandom_range(2048)));
				write_reg(REG_ASSIST_WINDOW_HIGH, 16'($urandom_range(4096, 2048)));
			end
		endcase
		cfg.valid <= 1'b0;
	endtask

	initial begin
		tick.valid = 1'b0;
		{tick.pilot_roll, tick.pilot_pitch, tick.vel_north, tick.vel_east, tick.vertical_speed,
			tick.yaw_sin, tick.yaw_cos, tick.yaw_stick, tick.pilot_throttle} = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_YAW_RATE_GAIN;
		cfg.data = '0;
		yaw_rate_gain = 1152; speed_gain = 800; speed_limit = 560;
		assist_gain = 1887; assist_max = 1229; window_low = 872; window_high = 3224;
		stick_lp = 0; brake = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 9; recv_idle_pct = 80;
		test_directed();
		test_random(300);
		test_backpressure();
		send_idle_pct = 80; recv_idle_pct = 9;
		test_config(0);
		test_directed();
		test_random(200);
		test_config(1);
		test_random(100);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_config(2);
		test_directed();
		test_random(120);
		test_config(3);
		test_random(300);
		drain();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
src/dmat_pkg.sv
src/dmat_if.sv
src/dmat_ctrl.sv
src/dmat_datapath.sv
src/drift_mode_attitude_throttle_step_unit.sv
verif/tb_drift_mode_attitude_throttle_step_unit.sv
